// ----- hw/rtl/dpfl_pkg.sv -----
// package for the demand-paging unit: default sizes, field widths,
// request and status codes shared by the core and its users
// no dependencies
package dpfl_pkg;

  // default sizing of the unit
  localparam int VIRT_PAGES_DEF  = 16;
  localparam int PAGE_BYTES_DEF  = 256;
  localparam int PHYS_FRAMES_DEF = 64;
  localparam int MAX_OWNED_DEF   = 16;

  // fixed field widths of the transactions
  localparam int PAGE_W   = 4;
  localparam int OFFSET_W = 8;
  localparam int FRAME_W  = 6;
  localparam int STATUS_W = 3;
  localparam int PADDR_W  = 14;
  localparam int FAULT_W  = 32;

  // request type codes
  localparam logic REQ_GRANT  = 1'b0;
  localparam logic REQ_ACCESS = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_HIT        = 3'd0,
    ST_FAULT_FREE = 3'd1,
    ST_FAULT_REPL = 3'd2,
    ST_NO_FRAME   = 3'd3,
    ST_GRANTED    = 3'd4,
    ST_REFUSED    = 3'd5
  } status_t;

endpackage

// ----- hw/rtl/demand_paging_fifo_lru_core.sv -----
// demand-paging core: page table, free-frame queue and replacement order list
// with FIFO or LRU eviction under a small sequencer
// depends on dpfl_pkg
//
// input channel (in_valid / in_ready): a grant adds in_grant_frame to the
// free-frame queue; an access translates in_virtual_page and in_page_offset.
// output channel (out_valid / out_ready): status, physical address, frame,
// evicted page and running fault count, one transaction per request.
// cfg_we / cfg_wdata set the policy (0 FIFO, 1 LRU); the user must write it only
// while nothing is in flight: the core does not enforce it. a grant, a miss or a
// FIFO hit passes through S_EXEC and S_OUT, which loads the output register and
// raises out_valid; an LRU hit first walks the order list in S_SEARCH, one entry
// per cycle through a single page comparator, up to the page's entry in the list.
// in_ready is high only while the sequencer is idle.
// synchronous active-low reset empties the page table, the free queue and the
// order list, clears the fault count and selects FIFO. a result waits in the
// output register while out_ready is low; the next request can be taken
// meanwhile but its result holds in the sequencer until the register frees.
module demand_paging_fifo_lru_core #(
  parameter int VIRT_PAGES  = dpfl_pkg::VIRT_PAGES_DEF,
  parameter int PAGE_BYTES  = dpfl_pkg::PAGE_BYTES_DEF,
  parameter int PHYS_FRAMES = dpfl_pkg::PHYS_FRAMES_DEF,
  parameter int MAX_OWNED   = dpfl_pkg::MAX_OWNED_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic                           cfg_wdata,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [dpfl_pkg::PAGE_W-1:0]    in_virtual_page,
  input  logic [dpfl_pkg::OFFSET_W-1:0]  in_page_offset,
  input  logic [dpfl_pkg::FRAME_W-1:0]   in_grant_frame,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dpfl_pkg::STATUS_W-1:0]  out_status,
  output logic [dpfl_pkg::PADDR_W-1:0]   out_physical_address,
  output logic [dpfl_pkg::FRAME_W-1:0]   out_frame,
  output logic [dpfl_pkg::PAGE_W-1:0]    out_evicted_page,
  output logic [dpfl_pkg::FAULT_W-1:0]   out_fault_count
);
  import dpfl_pkg::*;

  // derived widths
  localparam int OW  = (MAX_OWNED > 1) ? $clog2(MAX_OWNED) : 1;
  localparam int CW  = $clog2(MAX_OWNED + 1);
  localparam int VW  = (VIRT_PAGES > 1) ? $clog2(VIRT_PAGES) : 1;
  localparam int VXW = (VW > PAGE_W) ? VW : PAGE_W;
  localparam int RW  = 16;
  localparam int PFW = 20;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_OUT
  } state_t;

  // control state
  state_t             state_r, state_nxt;
  logic               policy_r, policy_nxt;
  logic [CW-1:0]      free_count_r, free_count_nxt;
  logic [CW-1:0]      order_count_r, order_count_nxt;
  logic [FAULT_W-1:0] faults_r, faults_nxt;
  logic               entry_valid_r [VIRT_PAGES];
  logic               entry_valid_nxt [VIRT_PAGES];
  logic               out_valid_r, out_valid_nxt;
  logic [OW-1:0]      idx_r, idx_nxt;

  // tables
  logic [FRAME_W-1:0] entry_frame_r [VIRT_PAGES];
  logic [FRAME_W-1:0] entry_frame_nxt [VIRT_PAGES];
  logic [FRAME_W-1:0] free_frames_r [MAX_OWNED];
  logic [FRAME_W-1:0] free_frames_nxt [MAX_OWNED];
  logic [FRAME_W-1:0] order_frames_r [MAX_OWNED];
  logic [FRAME_W-1:0] order_frames_nxt [MAX_OWNED];
  logic [PAGE_W-1:0]  order_pages_r [MAX_OWNED];
  logic [PAGE_W-1:0]  order_pages_nxt [MAX_OWNED];

  // latched request
  logic                type_r, type_nxt;
  logic [PAGE_W-1:0]   vp_r, vp_nxt;
  logic [OFFSET_W-1:0] off_r, off_nxt;
  logic [FRAME_W-1:0]  gf_r, gf_nxt;

  // result held by the sequencer
  status_t             res_status_r, res_status_nxt;
  logic [FRAME_W-1:0]  res_frm_r, res_frm_nxt;
  logic [PAGE_W-1:0]   res_evict_r, res_evict_nxt;
  logic                res_ok_r, res_ok_nxt;

  // output register
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [PADDR_W-1:0]  out_paddr_r, out_paddr_nxt;
  logic [FRAME_W-1:0]  out_frame_r, out_frame_nxt;
  logic [PAGE_W-1:0]   out_evict_r, out_evict_nxt;
  logic [FAULT_W-1:0]  out_faults_r, out_faults_nxt;

  // helpers
  logic [RW-1:0]       off_rem;
  logic [OFFSET_W-1:0] off_mod;
  logic [VXW-1:0]      vp_x;
  logic [VW-1:0]       vp_idx;
  logic                vp_in_range;
  logic [VXW-1:0]      ev_x;
  logic [VW-1:0]       ev_idx;
  logic [PFW-1:0]      paddr_full;
  logic [CW:0]         owned_sum;
  logic [OW-1:0]       last_idx;
  logic [CW-1:0]       idx_next_cnt;

  // offset modulo page size: restoring reduction, quotient below sixteen
  always_comb begin
    off_rem = RW'(off_r);
    for (int k = 3; k >= 0; k--) begin
      if (off_rem >= (RW'(PAGE_BYTES) << k)) begin
        off_rem = off_rem - (RW'(PAGE_BYTES) << k);
      end
    end
    off_mod = off_rem[OFFSET_W-1:0];
  end

  // page indexes into the page table
  assign vp_x        = VXW'(vp_r);
  assign vp_idx      = vp_x[VW-1:0];
  assign vp_in_range = (int'(vp_r) < VIRT_PAGES);
  assign ev_x        = VXW'(order_pages_r[0]);
  assign ev_idx      = ev_x[VW-1:0];

  // address of the result, from the stored frame and reduced offset
  assign paddr_full = PFW'(res_frm_r) * PFW'(PAGE_BYTES) + PFW'(off_r);

  assign owned_sum    = (CW + 1)'(free_count_r) + (CW + 1)'(order_count_r);
  assign last_idx     = OW'(order_count_r - CW'(1));
  assign idx_next_cnt = CW'(idx_r) + CW'(1);

  // sequencer and datapath next state
  always_comb begin
    state_nxt        = state_r;
    policy_nxt       = cfg_we ? cfg_wdata : policy_r;
    free_count_nxt   = free_count_r;
    order_count_nxt  = order_count_r;
    faults_nxt       = faults_r;
    entry_valid_nxt  = entry_valid_r;
    entry_frame_nxt  = entry_frame_r;
    free_frames_nxt  = free_frames_r;
    order_frames_nxt = order_frames_r;
    order_pages_nxt  = order_pages_r;
    idx_nxt          = idx_r;
    type_nxt         = type_r;
    vp_nxt           = vp_r;
    off_nxt          = off_r;
    gf_nxt           = gf_r;
    res_status_nxt   = res_status_r;
    res_frm_nxt      = res_frm_r;
    res_evict_nxt    = res_evict_r;
    res_ok_nxt       = res_ok_r;
    out_status_nxt   = out_status_r;
    out_paddr_nxt    = out_paddr_r;
    out_frame_nxt    = out_frame_r;
    out_evict_nxt    = out_evict_r;
    out_faults_nxt   = out_faults_r;
    in_ready         = 1'b0;

    // output register drains on its own handshake
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          type_nxt  = in_req_type;
          vp_nxt    = in_virtual_page;
          off_nxt   = in_page_offset;
          gf_nxt    = in_grant_frame;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        off_nxt       = off_mod;
        res_frm_nxt   = '0;
        res_evict_nxt = '0;
        res_ok_nxt    = 1'b0;
        state_nxt     = S_OUT;
        if (type_r == REQ_GRANT) begin
          // grant joins the tail of the free queue unless out of range or MAX_OWNED frames are owned
          res_frm_nxt = gf_r;
          if (int'(gf_r) >= PHYS_FRAMES || int'(owned_sum) >= MAX_OWNED) begin
            res_status_nxt = ST_REFUSED;
          end else begin
            free_frames_nxt[free_count_r[OW-1:0]] = gf_r;
            free_count_nxt = free_count_r + CW'(1);
            res_status_nxt = ST_GRANTED;
          end
        end else if (!vp_in_range) begin
          res_status_nxt = ST_NO_FRAME;
        end else if (entry_valid_r[vp_idx]) begin
          // hit; under lru walk the order list
          res_frm_nxt    = entry_frame_r[vp_idx];
          res_status_nxt = ST_HIT;
          res_ok_nxt     = 1'b1;
          if (policy_r && order_count_r != '0) begin
            idx_nxt   = '0;
            state_nxt = S_SEARCH;
          end
        end else if (free_count_r != '0) begin
          // miss, oldest free frame taken
          faults_nxt  = faults_r + FAULT_W'(1);
          res_frm_nxt = free_frames_r[0];
          for (int i = 0; i < MAX_OWNED - 1; i++) begin
            free_frames_nxt[i] = free_frames_r[i + 1];
          end
          free_count_nxt          = free_count_r - CW'(1);
          entry_frame_nxt[vp_idx] = free_frames_r[0];
          entry_valid_nxt[vp_idx] = 1'b1;
          if (int'(order_count_r) < MAX_OWNED) begin
            order_frames_nxt[order_count_r[OW-1:0]] = free_frames_r[0];
            order_pages_nxt[order_count_r[OW-1:0]]  = vp_r;
            order_count_nxt = order_count_r + CW'(1);
          end
          res_status_nxt = ST_FAULT_FREE;
          res_ok_nxt     = 1'b1;
        end else if (order_count_r != '0) begin
          // miss, head of the order list evicted and reused
          faults_nxt    = faults_r + FAULT_W'(1);
          res_frm_nxt   = order_frames_r[0];
          res_evict_nxt = order_pages_r[0];
          if (int'(order_pages_r[0]) < VIRT_PAGES) begin
            entry_valid_nxt[ev_idx] = 1'b0;
            entry_frame_nxt[ev_idx] = '0;
          end
          for (int i = 0; i < MAX_OWNED - 1; i++) begin
            order_frames_nxt[i] = order_frames_r[i + 1];
            order_pages_nxt[i]  = order_pages_r[i + 1];
          end
          order_frames_nxt[last_idx] = order_frames_r[0];
          order_pages_nxt[last_idx]  = vp_r;
          entry_frame_nxt[vp_idx]    = order_frames_r[0];
          entry_valid_nxt[vp_idx]    = 1'b1;
          res_status_nxt = ST_FAULT_REPL;
          res_ok_nxt     = 1'b1;
        end else begin
          res_status_nxt = ST_NO_FRAME;
        end
      end

      S_SEARCH: begin
        // one order entry compared per cycle
        if (order_pages_r[idx_r] == vp_r) begin
          for (int i = 0; i < MAX_OWNED - 1; i++) begin
            if (i >= int'(idx_r)) begin
              order_frames_nxt[i] = order_frames_r[i + 1];
              order_pages_nxt[i]  = order_pages_r[i + 1];
            end
          end
          order_frames_nxt[last_idx] = res_frm_r;
          order_pages_nxt[last_idx]  = vp_r;
          state_nxt = S_OUT;
        end else if (idx_next_cnt >= order_count_r) begin
          state_nxt = S_OUT;
        end else begin
          idx_nxt = idx_next_cnt[OW-1:0];
        end
      end

      S_OUT: begin
        // load the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_paddr_nxt  = res_ok_r ? paddr_full[PADDR_W-1:0] : '0;
          out_frame_nxt  = res_frm_r;
          out_evict_nxt  = (res_status_r == ST_FAULT_REPL) ? res_evict_r : '0;
          out_faults_nxt = faults_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      policy_r      <= 1'b0;
      free_count_r  <= '0;
      order_count_r <= '0;
      faults_r      <= '0;
      out_valid_r   <= 1'b0;
      idx_r         <= '0;
      for (int i = 0; i < VIRT_PAGES; i++) begin
        entry_valid_r[i] <= 1'b0;
      end
    end else begin
      state_r       <= state_nxt;
      policy_r      <= policy_nxt;
      free_count_r  <= free_count_nxt;
      order_count_r <= order_count_nxt;
      faults_r      <= faults_nxt;
      out_valid_r   <= out_valid_nxt;
      idx_r         <= idx_nxt;
      entry_valid_r <= entry_valid_nxt;
      entry_frame_r  <= entry_frame_nxt;
      free_frames_r  <= free_frames_nxt;
      order_frames_r <= order_frames_nxt;
      order_pages_r  <= order_pages_nxt;
      type_r        <= type_nxt;
      vp_r          <= vp_nxt;
      off_r         <= off_nxt;
      gf_r          <= gf_nxt;
      res_status_r  <= res_status_nxt;
      res_frm_r     <= res_frm_nxt;
      res_evict_r   <= res_evict_nxt;
      res_ok_r      <= res_ok_nxt;
      out_status_r  <= out_status_nxt;
      out_paddr_r   <= out_paddr_nxt;
      out_frame_r   <= out_frame_nxt;
      out_evict_r   <= out_evict_nxt;
      out_faults_r  <= out_faults_nxt;
    end
  end

  // result ports
  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_physical_address = out_paddr_r;
  assign out_frame            = out_frame_r;
  assign out_evicted_page     = out_evict_r;
  assign out_fault_count      = out_faults_r;

endmodule

// ----- tb/sv/demand_paging_fifo_lru_core_tb.sv -----
// self-checking testbench for the demand-paging core: page table, free queue and
// FIFO/LRU replacement predicted in a scoreboard class, random valid/ready traffic
// depends on dpfl_pkg and demand_paging_fifo_lru_core
`timescale 1ns / 100ps

module demand_paging_fifo_lru_core_tb;
  import dpfl_pkg::*;

  localparam int VIRT_PAGES  = VIRT_PAGES_DEF;
  localparam int PAGE_BYTES  = PAGE_BYTES_DEF;
  localparam int PHYS_FRAMES = PHYS_FRAMES_DEF;
  localparam int MAX_OWNED   = MAX_OWNED_DEF;

  // one entry of the replacement order: frame and the page mapped onto it
  typedef struct {
    bit [FRAME_W-1:0] frame;
    bit [PAGE_W-1:0]  page;
  } mapping_t;

  // expected result of one transaction
  typedef struct {
    status_t            status;
    bit [PADDR_W-1:0]   paddr;
    bit [FRAME_W-1:0]   frame;
    bit [PAGE_W-1:0]    evicted;
    bit [FAULT_W-1:0]   faults;
  } xlat_result_t;

  // page table, free queue and order list kept alongside the core
  class paging_tracker;
    bit                 lru;
    bit                 page_mapped[VIRT_PAGES];
    bit [FRAME_W-1:0]   page_frame[VIRT_PAGES];
    bit [FRAME_W-1:0]   free_q[$];
    mapping_t           age_q[$];
    bit [FAULT_W-1:0]   fault_total;
    xlat_result_t       awaiting[$];
    int                 mismatches;
    int                 status_seen[6];

    function new();
      lru = 1'b0;
      fault_total = '0;
      mismatches = 0;
      foreach (page_mapped[i]) begin
        page_mapped[i] = 1'b0;
        page_frame[i] = '0;
      end
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int owned();
      return free_q.size() + age_q.size();
    endfunction

    function int pending();
      return awaiting.size();
    endfunction

    task flag_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    // work out the result of an accepted transaction and update the tables
    function void take_request(bit rtype, bit [PAGE_W-1:0] vp, bit [OFFSET_W-1:0] off,
                               bit [FRAME_W-1:0] gf);
      xlat_result_t r;
      mapping_t     m;
      bit           ok;
      int           hit_at;
      r.status = ST_NO_FRAME;
      r.paddr = '0;
      r.frame = '0;
      r.evicted = '0;
      ok = 1'b0;
      hit_at = -1;
      if (rtype == REQ_GRANT) begin
        r.frame = gf;
        if (int'(gf) >= PHYS_FRAMES || owned() >= MAX_OWNED) begin
          r.status = ST_REFUSED;
        end else begin
          free_q.insert(free_q.size(), gf);
          r.status = ST_GRANTED;
        end
      end else if (page_mapped[vp]) begin
        r.frame = page_frame[vp];
        r.status = ST_HIT;
        ok = 1'b1;
        // lru hit moves the page to the most-recent end
        if (lru) begin
          foreach (age_q[i]) if (hit_at < 0 && age_q[i].page == vp) hit_at = i;
          if (hit_at >= 0) begin
            age_q.delete(hit_at);
            m.frame = page_frame[vp];
            m.page = vp;
            age_q.insert(age_q.size(), m);
          end
        end
      end else if (free_q.size() > 0) begin
        fault_total++;
        r.frame = free_q.pop_front();
        page_mapped[vp] = 1'b1;
        page_frame[vp] = r.frame;
        m.frame = r.frame;
        m.page = vp;
        age_q.insert(age_q.size(), m);
        r.status = ST_FAULT_FREE;
        ok = 1'b1;
      end else if (age_q.size() > 0) begin
        // evict the head of the order list and reuse its frame
        m = age_q.pop_front();
        fault_total++;
        r.frame = m.frame;
        r.evicted = m.page;
        page_mapped[m.page] = 1'b0;
        page_frame[m.page] = '0;
        page_mapped[vp] = 1'b1;
        page_frame[vp] = m.frame;
        m.page = vp;
        age_q.insert(age_q.size(), m);
        r.status = ST_FAULT_REPL;
        ok = 1'b1;
      end
      if (ok) r.paddr = PADDR_W'(int'(r.frame) * PAGE_BYTES + int'(off) % PAGE_BYTES);
      r.faults = fault_total;
      awaiting.insert(awaiting.size(), r);
    endfunction

    // compare a delivered result with the oldest outstanding one
    task match_result(logic [STATUS_W-1:0] st, logic [PADDR_W-1:0] pa,
                      logic [FRAME_W-1:0] fr, logic [PAGE_W-1:0] ev,
                      logic [FAULT_W-1:0] fc);
      xlat_result_t e;
      if (awaiting.size() == 0) begin
        flag_mismatch($sformatf("result with nothing outstanding, status %0d", st));
        return;
      end
      e = awaiting.pop_front();
      status_seen[int'(e.status)]++;
      if (st !== e.status)
        flag_mismatch($sformatf("status %0d, expected %s", st, e.status.name()));
      if (pa !== e.paddr)
        flag_mismatch($sformatf("physical address %h, expected %h", pa, e.paddr));
      if (fr !== e.frame)
        flag_mismatch($sformatf("frame %0d, expected %0d", fr, e.frame));
      if (ev !== e.evicted)
        flag_mismatch($sformatf("evicted page %0d, expected %0d", ev, e.evicted));
      if (fc !== e.faults)
        flag_mismatch($sformatf("fault count %0d, expected %0d", fc, e.faults));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic                 cfg_wdata = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_req_type = 1'b0;
  logic [PAGE_W-1:0]    in_virtual_page = '0;
  logic [OFFSET_W-1:0]  in_page_offset = '0;
  logic [FRAME_W-1:0]   in_grant_frame = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [PADDR_W-1:0]   out_physical_address;
  logic [FRAME_W-1:0]   out_frame;
  logic [PAGE_W-1:0]    out_evicted_page;
  logic [FAULT_W-1:0]   out_fault_count;

  paging_tracker sb;
  bit steady = 1'b0;     // no idling on either side
  int hold_cycles = 0;   // long receiver hold-off requested by the stimulus
  int rx_gap = 0;
  int sent = 0;

  demand_paging_fifo_lru_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_type          (in_req_type),
    .in_virtual_page      (in_virtual_page),
    .in_page_offset       (in_page_offset),
    .in_grant_frame       (in_grant_frame),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_physical_address (out_physical_address),
    .out_frame            (out_frame),
    .out_evicted_page     (out_evicted_page),
    .out_fault_count      (out_fault_count)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAIL demand_paging_fifo_lru_core");
    $finish;
  end

  // transaction monitor: results checked before new requests are noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.match_result(out_status, out_physical_address, out_frame, out_evicted_page,
                        out_fault_count);
      if (in_valid && in_ready)
        sb.take_request(in_req_type, in_virtual_page, in_page_offset, in_grant_frame);
    end
  end

  // result side: long hold-off, random stall bursts or ready
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 11) == 0) begin
        rx_gap = $urandom_range(1, 18) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // offer one request and wait for it to be taken, then maybe idle
  task automatic offer(bit rtype, bit [PAGE_W-1:0] vp, bit [OFFSET_W-1:0] off,
                       bit [FRAME_W-1:0] gf);
    in_valid <= 1'b1;
    in_req_type <= rtype;
    in_virtual_page <= vp;
    in_page_offset <= off;
    in_grant_frame <= gf;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (!steady && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // unused fields carry random values
  task automatic grant(bit [FRAME_W-1:0] gf);
    offer(REQ_GRANT, PAGE_W'($urandom), OFFSET_W'($urandom), gf);
  endtask

  task automatic access(bit [PAGE_W-1:0] vp, bit [OFFSET_W-1:0] off);
    offer(REQ_ACCESS, vp, off, FRAME_W'($urandom));
  endtask

  // wait until every outstanding result has been delivered
  task automatic settle(int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_policy(bit lru);
    settle(4);
    cfg_we <= 1'b1;
    cfg_wdata <= lru;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.lru = lru;
  endtask

  // random traffic: grants until about target frames are owned, accesses
  // mostly over a working set a little larger than the frames owned
  task automatic run_phase(int n, int target);
    int own;
    int top;
    for (int k = 0; k < n; k++) begin
      own = sb.owned();
      top = (own + 2 > VIRT_PAGES - 1) ? VIRT_PAGES - 1 : own + 2;
      if ((own < target && $urandom_range(0, 3) == 0) || $urandom_range(0, 39) == 0)
        grant(FRAME_W'($urandom_range(0, PHYS_FRAMES - 1)));
      else if ($urandom_range(0, 2) != 0)
        access(PAGE_W'($urandom_range(0, top)), OFFSET_W'($urandom));
      else
        access(PAGE_W'($urandom_range(0, VIRT_PAGES - 1)), OFFSET_W'($urandom));
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // fifo after reset: miss with no frame, extremes, hit without reorder,
    // eviction of the oldest, the same frame granted twice
    access(4'd3, 8'h55);
    grant(6'd63);
    grant(6'd0);
    access(4'd0, 8'h00);
    access(4'd15, 8'hFF);
    access(4'd0, 8'hAA);
    access(4'd7, 8'h01);
    access(4'd15, 8'h80);
    grant(6'd63);
    access(4'd9, 8'h7F);
    access(4'd2, 8'hFE);

    // lru: hits reorder the list before eviction
    set_policy(1'b1);
    access(4'd7, 8'h33);
    access(4'd4, 8'hCC);
    access(4'd2, 8'h0F);
    access(4'd11, 8'hF0);
    access(4'd4, 8'h00);

    // random phases, policy switched each time with the order list kept
    run_phase(130, 4);
    set_policy(1'b0);
    run_phase(130, 7);
    set_policy(1'b1);
    hold_cycles = 300;
    run_phase(130, 10);
    set_policy(1'b0);
    run_phase(130, 12);
    set_policy(1'b1);
    run_phase(130, 14);

    // capacity: fill up to the limit, then refusals
    repeat (MAX_OWNED) grant(FRAME_W'($urandom));
    grant(6'd0);
    grant(6'd63);

    // last part without idling
    settle(4);
    steady = 1'b1;
    run_phase(130, MAX_OWNED);
    settle(24);

    $display("covered %0d transactions under FIFO and LRU: %0d hits, %0d free-frame faults,",
             sent, sb.status_seen[ST_HIT], sb.status_seen[ST_FAULT_FREE]);
    $display("  %0d replacements, %0d no-frame misses, %0d grants, %0d refused, %0d faults",
             sb.status_seen[ST_FAULT_REPL], sb.status_seen[ST_NO_FRAME],
             sb.status_seen[ST_GRANTED], sb.status_seen[ST_REFUSED], sb.fault_total);
    if (sb.mismatches == 0) begin
      $display("PASS demand_paging_fifo_lru_core");
    end else begin
      $display("FAIL demand_paging_fifo_lru_core");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/dpfl_pkg.sv
hw/rtl/demand_paging_fifo_lru_core.sv
tb/sv/demand_paging_fifo_lru_core_tb.sv
